### sv/tsbg_pkg.sv
// Shared types and constants for the term signature bit generator.
`timescale 1ns / 1ps
package tsbg_pkg;
    localparam int MAX_BITS_DEF = 31;
    localparam logic [31:0] LCG_MUL = 32'd1103515245;
    localparam logic [31:0] LCG_ADD = 32'd12345;
    localparam logic [15:0] CW_SIZE_RESET = 16'd512;
    localparam logic [1:0] KIND_SEG = 2'd0;
    localparam logic [1:0] KIND_REC = 2'd1;
    localparam logic [1:0] KIND_SUM = 2'd2;
    localparam logic CFG_SEG = 1'b0;
    localparam logic CFG_REC = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take_char;   // absorb an input character
        logic load_seed;   // latch key into generator word 0
        logic lcg_step;    // one linear step into the next word
        logic draw;        // one lagged generator draw
        logic save_clust;  // capture warm-up result
        logic remix;       // mix key with rotated parent seed
        logic div_start;   // start a modulo on the last draw
        logic div_rec;     // modulus is the record size
        logic clear_name;  // back to reset name state
    } tsbg_cmd_t;

    typedef struct packed {
        logic div_done;
        logic gather_done;
    } tsbg_sts_t;

    function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] n);
        logic [63:0] w;
        w = {v, v} << n;
        return w[63:32];
    endfunction
endpackage

### sv/tsbg_datapath.sv
// Datapath: key accumulator, lagged generator, modulo unit and gather.
`timescale 1ns / 1ps
module tsbg_datapath
    import tsbg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  tsbg_cmd_t   cmd,
    output tsbg_sts_t   sts,
    input  logic [7:0]  key_char,
    input  logic [31:0] seed_in,
    input  logic [4:0]  node_number,
    input  logic [4:0]  arg_count,
    input  logic [30:0] choice_vector,
    input  logic [15:0] seg_size,
    input  logic [15:0] rec_size,
    output logic [15:0] bit_position,
    output logic [31:0] new_seed,
    output logic [30:0] cluster_hash,
    output logic [30:0] gathered_bits
);
    logic [31:0] key_hash_reg, key_hash_next;
    logic [31:0] dec_reg, dec_next;
    logic [4:0]  pos_reg, pos_next;
    logic        num_reg, num_next;
    logic        first_reg, first_next;
    logic        ended_reg, ended_next;
    logic [31:0] s_reg [4];
    logic [1:0]  f_reg, r_reg, lcg_idx_reg;
    logic [31:0] x_reg;
    logic [30:0] clust_reg;
    logic [31:0] prod_reg;
    // Fields of the item being absorbed; the last one of a name stays for the run.
    logic [31:0] seed_in_reg;
    logic [4:0]  node_reg, nargs_reg;
    logic [30:0] cv_reg;
    // modulo unit, restoring, one quotient bit a cycle
    logic [21:0] div_num_reg;
    logic [16:0] div_rem_reg;
    logic [15:0] div_den_reg;
    logic [4:0]  div_cnt_reg;
    logic        div_busy_reg;
    logic        div_zero_reg;
    // gather unit, one choice vector position a cycle from the top down
    logic [30:0] gat_cv_reg, gat_hash_reg, gat_bits_reg;
    logic [4:0]  gat_cnt_reg;
    logic        gat_busy_reg;
    logic        is_digit;
    logic [31:0] sum;
    logic [16:0] trial;

    assign is_digit = (key_char >= 8'd48) && (key_char <= 8'd57);
    assign sum = s_reg[f_reg] + s_reg[r_reg];
    assign trial = {div_rem_reg[15:0], div_num_reg[21]};

    always_comb
    begin
        logic [4:0] knt;
        logic       nm;
        key_hash_next = key_hash_reg;
        dec_next = dec_reg;
        pos_next = pos_reg;
        num_next = num_reg;
        first_next = first_reg;
        ended_next = ended_reg;
        knt = pos_reg + {pos_reg[1:0], 3'b000};
        nm = first_reg ? is_digit : num_reg;
        if (cmd.clear_name)
        begin
            key_hash_next = '0;
            dec_next = '0;
            pos_next = '0;
            num_next = 1'b0;
            first_next = 1'b1;
            ended_next = 1'b0;
        end
        else if (cmd.take_char && !ended_reg)
        begin
            num_next = nm;
            first_next = 1'b0;
            if (nm)
            begin
                if (is_digit)
                    dec_next = {dec_reg[28:0], 3'b000} + {dec_reg[30:0], 1'b0}
                               + {28'd0, key_char[3:0]};
                else
                    ended_next = 1'b1;
            end
            else if (key_char == 8'd0)
                ended_next = 1'b1;
            else
            begin
                key_hash_next = key_hash_reg ^ rotl32({24'd0, key_char}, knt);
                pos_next = pos_reg + 5'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_hash_reg <= '0;
            dec_reg <= '0;
            pos_reg <= '0;
            num_reg <= 1'b0;
            first_reg <= 1'b1;
            ended_reg <= 1'b0;
            div_busy_reg <= 1'b0;
            gat_busy_reg <= 1'b0;
        end
        else
        begin
            key_hash_reg <= key_hash_next;
            dec_reg <= dec_next;
            pos_reg <= pos_next;
            num_reg <= num_next;
            first_reg <= first_next;
            ended_reg <= ended_next;
            if (cmd.div_start)
                div_busy_reg <= 1'b1;
            else if (div_busy_reg && div_cnt_reg == 5'd21)
                div_busy_reg <= 1'b0;
            if (cmd.save_clust)
                gat_busy_reg <= 1'b1;
            else if (gat_busy_reg && gat_cnt_reg == 5'd0)
                gat_busy_reg <= 1'b0;
        end
    end

    // Generator words; the linear step uses a registered product.
    always_ff @(posedge clk)
    begin
        if (cmd.take_char)
        begin
            seed_in_reg <= seed_in;
            node_reg <= node_number;
            nargs_reg <= arg_count;
            cv_reg <= choice_vector;
        end
        if (cmd.load_seed)
        begin
            s_reg[0] <= {1'b0, num_reg ? dec_reg[30:0] : key_hash_reg[30:0]};
            f_reg <= 2'd3;
            r_reg <= 2'd0;
            lcg_idx_reg <= 2'd0;
            prod_reg <= {1'b0, num_reg ? dec_reg[30:0] : key_hash_reg[30:0]} * LCG_MUL;
        end
        else if (cmd.lcg_step)
        begin
            s_reg[lcg_idx_reg + 2'd1] <= prod_reg + LCG_ADD;
            prod_reg <= (prod_reg + LCG_ADD) * LCG_MUL;
            lcg_idx_reg <= lcg_idx_reg + 2'd1;
        end
        else if (cmd.draw)
        begin
            s_reg[f_reg] <= sum;
            x_reg <= {1'b0, sum[31:1]};
            f_reg <= f_reg + 2'd1;
            r_reg <= (f_reg == 2'd3) ? r_reg + 2'd1 : r_reg + 2'd1;
        end
        else if (cmd.remix)
        begin
            s_reg[0] <= rotl32(x_reg, node_reg) ^ rotl32(seed_in_reg, nargs_reg + 5'd1);
            x_reg <= rotl32(x_reg, node_reg) ^ rotl32(seed_in_reg, nargs_reg + 5'd1);
            f_reg <= 2'd3;
            r_reg <= 2'd0;
        end
        // Highest set positions of the choice vector take the highest hash bits.
        if (cmd.save_clust)
        begin
            clust_reg <= x_reg[30:0];
            gat_cv_reg <= cv_reg;
            gat_hash_reg <= x_reg[30:0];
            gat_bits_reg <= '0;
            gat_cnt_reg <= 5'd30;
        end
        else if (gat_busy_reg)
        begin
            gat_bits_reg <= {gat_bits_reg[29:0], gat_cv_reg[30] & gat_hash_reg[30]};
            gat_cv_reg <= {gat_cv_reg[29:0], 1'b0};
            if (gat_cv_reg[30])
                gat_hash_reg <= {gat_hash_reg[29:0], 1'b0};
            gat_cnt_reg <= gat_cnt_reg - 5'd1;
        end
        if (cmd.div_start)
        begin
            div_num_reg <= x_reg[31:10];
            div_den_reg <= cmd.div_rec ? rec_size : seg_size;
            div_zero_reg <= (cmd.div_rec ? rec_size : seg_size) == 16'd0;
            div_rem_reg <= '0;
            div_cnt_reg <= '0;
        end
        else if (div_busy_reg)
        begin
            div_num_reg <= {div_num_reg[20:0], 1'b0};
            div_cnt_reg <= div_cnt_reg + 5'd1;
            if (trial >= {1'b0, div_den_reg})
                div_rem_reg <= trial - {1'b0, div_den_reg};
            else
                div_rem_reg <= trial;
        end
    end

    assign sts.div_done = !div_busy_reg;
    assign sts.gather_done = !gat_busy_reg;
    assign bit_position = div_zero_reg ? 16'd0 : div_rem_reg[15:0];
    assign new_seed = x_reg;
    assign cluster_hash = clust_reg;
    assign gathered_bits = gat_bits_reg;
endmodule

### sv/tsbg_ctrl.sv
// Controller: sequences warm-up, draws, modulo runs and result items.
`timescale 1ns / 1ps
module tsbg_ctrl
    import tsbg_pkg::*;
#(
    parameter int MAX_BITS = MAX_BITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       in_last,
    input  logic [4:0] seg_bit_count,
    input  logic [4:0] rec_bit_count,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] out_kind,
    output tsbg_cmd_t  cmd,
    input  tsbg_sts_t  sts
);
    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_LCG   = 8'b00000010,
        S_WARM  = 8'b00000100,
        S_REMIX = 8'b00001000,
        S_DRAW  = 8'b00010000,
        S_DIV   = 8'b00100000,
        S_OUT   = 8'b01000000,
        S_SUM   = 8'b10000000
    } state_t;

    state_t     state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic [4:0] nseg_reg, nseg_next, nrec_reg, nrec_next;
    logic       rec_reg, rec_next;

    localparam logic [4:0] MAXB = 5'(MAX_BITS);

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        nseg_next = nseg_reg;
        nrec_next = nrec_reg;
        rec_next = rec_reg;
        cmd = '0;
        cmd.div_rec = rec_reg;
        in_ready = 1'b0;
        out_valid = 1'b0;
        out_kind = rec_reg ? KIND_REC : KIND_SEG;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.take_char = 1'b1;
                    if (in_last)
                    begin
                        state_next = S_LCG;
                        cnt_next = '0;
                        nseg_next = (seg_bit_count > MAXB) ? MAXB : seg_bit_count;
                        nrec_next = (rec_bit_count > MAXB) ? MAXB : rec_bit_count;
                    end
                end
            end
            S_LCG:
            begin
                if (cnt_reg == 5'd0)
                    cmd.load_seed = 1'b1;
                else
                    cmd.lcg_step = 1'b1;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd3)
                begin
                    state_next = S_WARM;
                    cnt_next = '0;
                end
            end
            S_WARM:
            begin
                cmd.draw = 1'b1;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd3)
                    state_next = S_REMIX;
            end
            S_REMIX:
            begin
                cmd.save_clust = 1'b1;
                cmd.remix = 1'b1;
                rec_next = 1'b0;
                cnt_next = '0;
                state_next = (nseg_reg != 0) ? S_DRAW : (nrec_reg != 0) ? S_DRAW : S_SUM;
                if (nseg_reg == 0)
                    rec_next = 1'b1;
            end
            S_DRAW:
            begin
                cmd.draw = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (cnt_reg[4] == 1'b0 && !cnt_reg[0] && sts.div_done && cnt_reg == 5'd0)
                begin
                    cmd.div_start = 1'b1;
                    cnt_next = 5'd2;
                end
                else if (sts.div_done && cnt_reg == 5'd2)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    cnt_next = '0;
                    if (!rec_reg)
                    begin
                        nseg_next = nseg_reg - 5'd1;
                        if (nseg_reg == 5'd1)
                        begin
                            rec_next = 1'b1;
                            state_next = (nrec_reg != 0) ? S_DRAW : S_SUM;
                        end
                        else
                            state_next = S_DRAW;
                    end
                    else
                    begin
                        nrec_next = nrec_reg - 5'd1;
                        state_next = (nrec_reg == 5'd1) ? S_SUM : S_DRAW;
                    end
                end
            end
            S_SUM:
            begin
                // The summary waits until the choice vector gather has finished.
                out_valid = sts.gather_done;
                out_kind = KIND_SUM;
                if (sts.gather_done && out_ready)
                begin
                    cmd.clear_name = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg <= '0;
            nseg_reg <= '0;
            nrec_reg <= '0;
            rec_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            nseg_reg <= nseg_next;
            nrec_reg <= nrec_next;
            rec_reg <= rec_next;
        end
    end
endmodule

### sv/term_signature_bit_generator.sv
// Top level of the term signature bit generator.
//  channel | direction | contents
//  s_axis  | in        | tdata: key_char, seed_in, node_number, arg_count, counts, choice_vector
//  m_axis  | out       | tdata: bit_position, new_seed, cluster_hash, gathered_bits
//  cfg     | in        | cfg_wr, cfg_index, cfg_data
// A plain character is absorbed and the block stays ready for the next. A last
// character starts seeding and warm-up, then the position results, each paced
// by the one-bit-a-cycle modulo unit, then the summary item, which also
// waits for the serial gather of the choice vector.
// Reset clears the name state and sets both codeword sizes to 512.
// Output stalls hold the sequencer; no input is taken while a run is active.
`timescale 1ns / 1ps
module term_signature_bit_generator
    import tsbg_pkg::*;
#(
    parameter int MAX_BITS = MAX_BITS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // key_char[7:0], seed_in[39:8], node_number[44:40], arg_count[60:56],
    // seg_bit_count[65:61], rec_bit_count[70:66], choice_vector[101:71]
    input  logic [103:0] s_axis_tdata,
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // bit_position[15:0], new_seed[47:16], cluster_hash[78:48], gathered_bits[109:79]
    output logic [111:0] m_axis_tdata,
    // kind[1:0]
    output logic [1:0]   m_axis_tuser,
    output logic         m_axis_tlast,
    input  logic         cfg_wr,
    input  logic         cfg_index,
    input  logic [15:0]  cfg_data
);
    tsbg_cmd_t   cmd;
    tsbg_sts_t   sts;
    logic [15:0] seg_size_reg, rec_size_reg;
    logic [15:0] bpos;
    logic [31:0] nseed;
    logic [30:0] chash, cbits;
    logic [1:0]  kind;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_size_reg <= CW_SIZE_RESET;
            rec_size_reg <= CW_SIZE_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_index)
                CFG_SEG: seg_size_reg <= cfg_data;
                CFG_REC: rec_size_reg <= cfg_data;
            endcase
        end
    end

    tsbg_ctrl #(.MAX_BITS(MAX_BITS)) u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_last(s_axis_tlast),
        .seg_bit_count(s_axis_tdata[65:61]), .rec_bit_count(s_axis_tdata[70:66]),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_kind(kind),
        .cmd(cmd), .sts(sts)
    );

    tsbg_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
        .key_char(s_axis_tdata[7:0]), .seed_in(s_axis_tdata[39:8]),
        .node_number(s_axis_tdata[44:40]), .arg_count(s_axis_tdata[60:56]),
        .choice_vector(s_axis_tdata[101:71]),
        .seg_size(seg_size_reg), .rec_size(rec_size_reg),
        .bit_position(bpos), .new_seed(nseed), .cluster_hash(chash), .gathered_bits(cbits)
    );

    // The summary item carries only seed, hash and choice bits.
    always_comb
    begin
        m_axis_tuser = kind;
        m_axis_tlast = (kind == KIND_SUM);
        if (kind == KIND_SUM)
            m_axis_tdata = {2'b00, cbits, chash, nseed, 16'd0};
        else
            m_axis_tdata = {96'd0, bpos};
    end

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input taken while a result is pending");
    a_last_is_sum: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[15:0] == 16'd0)
        else $error("summary item carries a position");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tuser))
        else $error("result dropped under stall");
endmodule
